FILE: rtl/core/jfss_pkg.sv
`timescale 1ns / 1ps
package jfss_pkg;

    // Parser phase codes
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_SOI_FIRST  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SOI_SECOND = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SCAN       = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MARKER     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEN_HIGH   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LEN_LOW    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_BODY       = 3'd6;

    // Marker and byte values
    localparam logic [7:0] BYTE_PREFIX = 8'hff;
    localparam logic [7:0] MARK_SOI    = 8'hd8;
    localparam logic [7:0] MARK_EOI    = 8'hd9;
    localparam logic [7:0] MARK_SOS    = 8'hda;

    // Frame header: precision, height (2), width (2), then the rest
    localparam logic [2:0] FIELD_HEIGHT_HI = 3'd1;
    localparam logic [2:0] FIELD_HEIGHT_LO = 3'd2;
    localparam logic [2:0] FIELD_WIDTH_HI  = 3'd3;
    localparam logic [2:0] FIELD_WIDTH_LO  = 3'd4;
    localparam logic [2:0] FIELD_DONE      = 3'd5;

    localparam logic [15:0] MIN_SEG_LEN   = 16'd2;
    localparam logic [15:0] MIN_FRAME_LEN = 16'd7;

    // One result request
    typedef struct packed {
        logic        found;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_result;

    // Start-of-frame markers C0-C3, C5-C7, C9-CB, CD-CF
    function automatic logic is_frame_marker(input logic [7:0] m);
        logic r;
        r = 1'b0;
        case (m) inside
            [8'hc0:8'hc3], [8'hc5:8'hc7], [8'hc9:8'hcb], [8'hcd:8'hcf]: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/jfss_parser.sv
`timescale 1ns / 1ps
module jfss_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_res_valid,
    output jfss_pkg::t_result o_res
);
    import jfss_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [15:0]        r_remaining, n_remaining;
    logic [7:0]         r_len_high, n_len_high;
    logic               r_in_frame, n_in_frame;
    logic [2:0]         r_field_idx, n_field_idx;
    logic [15:0]        r_width, n_width;
    logic [15:0]        r_height, n_height;
    logic               r_decided, n_decided;

    logic        fail;
    logic        success;
    logic [15:0] seg_len;
    logic [15:0] rem_dec;

    assign seg_len = {r_len_high, i_byte};
    assign rem_dec = r_remaining - 16'd1;

    // Next state for one accepted byte
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_len_high  = r_len_high;
        n_in_frame  = r_in_frame;
        n_field_idx = r_field_idx;
        n_width     = r_width;
        n_height    = r_height;
        n_decided   = r_decided;
        fail        = 1'b0;
        success     = 1'b0;

        if (!r_decided) begin
            case (r_phase)
                PH_SOI_FIRST: begin
                    if (i_byte != BYTE_PREFIX) fail = 1'b1;
                    else n_phase = PH_SOI_SECOND;
                end
                PH_SOI_SECOND: begin
                    if (i_byte != MARK_SOI) fail = 1'b1;
                    else n_phase = PH_SCAN;
                end
                PH_SCAN: begin
                    if (i_byte == BYTE_PREFIX) n_phase = PH_MARKER;
                end
                PH_MARKER: begin
                    // extra fill bytes stay here
                    if (i_byte == MARK_EOI || i_byte == MARK_SOS) begin
                        fail = 1'b1;
                    end else if (i_byte != BYTE_PREFIX) begin
                        n_in_frame  = is_frame_marker(i_byte);
                        n_field_idx = 3'd0;
                        n_phase     = PH_LEN_HIGH;
                    end
                end
                PH_LEN_HIGH: begin
                    n_len_high = i_byte;
                    n_phase    = PH_LEN_LOW;
                end
                PH_LEN_LOW: begin
                    if (seg_len < MIN_SEG_LEN) begin
                        fail = 1'b1;
                    end else if (r_in_frame && seg_len < MIN_FRAME_LEN) begin
                        fail = 1'b1;
                    end else begin
                        n_remaining = seg_len - MIN_SEG_LEN;
                        n_phase     = (seg_len == MIN_SEG_LEN) ? PH_SCAN : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_in_frame) begin
                        case (r_field_idx)
                            FIELD_HEIGHT_HI: n_height = {i_byte, r_height[7:0]};
                            FIELD_HEIGHT_LO: n_height = {r_height[15:8], i_byte};
                            FIELD_WIDTH_HI:  n_width  = {i_byte, r_width[7:0]};
                            FIELD_WIDTH_LO:  n_width  = {r_width[15:8], i_byte};
                            default: ;
                        endcase
                        if (r_field_idx < FIELD_DONE) n_field_idx = r_field_idx + 3'd1;
                    end
                    n_remaining = rem_dec;
                    if (rem_dec == 16'd0) begin
                        if (r_in_frame) begin
                            if (n_width != 16'd0 && n_height != 16'd0) success = 1'b1;
                            else fail = 1'b1;
                        end else begin
                            n_phase = PH_SCAN;
                        end
                    end
                end
                default: n_phase = PH_SCAN;
            endcase
            // buffer ended undecided
            if (!success && i_last) fail = 1'b1;
            if (fail || success) n_decided = 1'b1;
        end

        // final byte returns everything to reset values
        if (i_last) begin
            n_phase     = PH_SOI_FIRST;
            n_remaining = 16'd0;
            n_len_high  = 8'd0;
            n_in_frame  = 1'b0;
            n_field_idx = 3'd0;
            n_width     = 16'd0;
            n_height    = 16'd0;
            n_decided   = 1'b0;
        end
    end

    // Result request for this byte
    always_comb begin
        o_res_valid        = i_accept && (fail || success);
        o_res.found        = success;
        o_res.image_width  = success ? n_width  : 16'd0;
        o_res.image_height = success ? n_height : 16'd0;
        if (success) begin
            o_res.image_width  = (r_field_idx == FIELD_WIDTH_LO) ? {r_width[15:8], i_byte}
                                                                  : r_width;
            o_res.image_height = r_height;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SOI_FIRST;
            r_remaining <= 16'd0;
            r_len_high  <= 8'd0;
            r_in_frame  <= 1'b0;
            r_field_idx <= 3'd0;
            r_width     <= 16'd0;
            r_height    <= 16'd0;
            r_decided   <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_len_high  <= n_len_high;
            r_in_frame  <= n_in_frame;
            r_field_idx <= n_field_idx;
            r_width     <= n_width;
            r_height    <= n_height;
            r_decided   <= n_decided;
        end
    end

endmodule

FILE: rtl/core/jpeg_frame_size_scanner_unit.sv
`timescale 1ns / 1ps
// Result requests are registered: valid in the cycle after the deciding byte.
// One byte per cycle unless the output stalls; the parser updates once per byte.
// The output register holds one result; a new byte is taken while it is taken or empty.
// Reset (synchronous, active low) clears parser state and the output valid.
// Parser state also returns to its reset values after each final byte.
module jpeg_frame_size_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] image_width, [31:16] image_height
    output logic        o_m_axis_tuser    // found
);
    import jfss_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    // Take a byte whenever the output slot is free or draining
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    jfss_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && o_s_axis_tready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.found;
    assign o_m_axis_tdata  = {r_out.image_height, r_out.image_width};

endmodule

FILE: sim/tb_jpeg_frame_size_scanner_unit.sv
`timescale 1ns / 1ps
module tb_jpeg_frame_size_scanner_unit;
    import jfss_pkg::*;

    // Marker codes used by the stimulus
    localparam logic [7:0] MARK_SOF0 = 8'hc0;
    localparam logic [7:0] MARK_RST0 = 8'hd0;

    localparam int TOTAL_BYTES = 1700;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 800;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    typedef enum logic [1:0] {
        SCAN_OPEN,
        SCAN_FAIL,
        SCAN_FOUND
    } t_scan_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;     // [7:0] data_byte
    logic        i_s_axis_tlast = 1'b0;   // last_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;          // [15:0] image_width, [31:16] image_height
    logic        o_m_axis_tuser;          // found

    jpeg_frame_size_scanner_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Pending bytes, staging buffer, expected frame sizes
    t_stream_byte byte_q[$];
    logic [7:0]   buf_q[$];
    t_result      frame_size_q[$];

    int n_errors = 0;
    int n_total = 0;
    int n_accepted = 0;
    int rx_hold_left = 0;
    bit rx_hold_done = 1'b0;

    // Scanner state mirror
    logic [PHASE_W-1:0] scan_phase;
    logic [15:0]        seg_left;
    logic [7:0]         len_hi;
    logic               sof_segment;
    logic [2:0]         field_idx;
    logic [15:0]        cap_width;
    logic [15:0]        cap_height;
    logic               size_decided;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    function automatic logic is_sof_marker(input logic [7:0] m);
        return (m >= 8'hc0 && m <= 8'hc3) || (m >= 8'hc5 && m <= 8'hc7) ||
               (m >= 8'hc9 && m <= 8'hcb) || (m >= 8'hcd && m <= 8'hcf);
    endfunction

    task automatic clear_scan_state();
        scan_phase   = PH_SOI_FIRST;
        seg_left     = '0;
        len_hi       = '0;
        sof_segment  = 1'b0;
        field_idx    = '0;
        cap_width    = '0;
        cap_height   = '0;
        size_decided = 1'b0;
    endtask

    // Advance the mirror by one byte; queue the frame size once decided
    task automatic scan_jpeg_byte(input logic [7:0] b, input logic last);
        t_scan_outcome verdict;
        logic [15:0]   seg_len;
        t_result       res;
        verdict = SCAN_OPEN;
        if (!size_decided) begin
            case (scan_phase)
                PH_SOI_FIRST: begin
                    if (b != BYTE_PREFIX) verdict = SCAN_FAIL;
                    else scan_phase = PH_SOI_SECOND;
                end
                PH_SOI_SECOND: begin
                    if (b != MARK_SOI) verdict = SCAN_FAIL;
                    else scan_phase = PH_SCAN;
                end
                PH_SCAN: begin
                    if (b == BYTE_PREFIX) scan_phase = PH_MARKER;
                end
                PH_MARKER: begin
                    // fill bytes keep us here
                    if (b == BYTE_PREFIX) begin
                    end else if (b == MARK_EOI || b == MARK_SOS) begin
                        verdict = SCAN_FAIL;
                    end else begin
                        sof_segment = is_sof_marker(b);
                        field_idx   = '0;
                        scan_phase  = PH_LEN_HIGH;
                    end
                end
                PH_LEN_HIGH: begin
                    len_hi     = b;
                    scan_phase = PH_LEN_LOW;
                end
                PH_LEN_LOW: begin
                    seg_len = {len_hi, b};
                    if (seg_len < MIN_SEG_LEN) begin
                        verdict = SCAN_FAIL;
                    end else if (sof_segment && seg_len < MIN_FRAME_LEN) begin
                        verdict = SCAN_FAIL;
                    end else begin
                        seg_left   = seg_len - MIN_SEG_LEN;
                        scan_phase = (seg_left == 16'd0) ? PH_SCAN : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (sof_segment) begin
                        case (field_idx)
                            FIELD_HEIGHT_HI: cap_height[15:8] = b;
                            FIELD_HEIGHT_LO: cap_height[7:0]  = b;
                            FIELD_WIDTH_HI:  cap_width[15:8]  = b;
                            FIELD_WIDTH_LO:  cap_width[7:0]   = b;
                            default: ;
                        endcase
                        if (field_idx < FIELD_DONE) field_idx = field_idx + 3'd1;
                    end
                    seg_left = seg_left - 16'd1;
                    if (seg_left == 16'd0) begin
                        if (sof_segment) begin
                            verdict = (cap_width != 16'd0 && cap_height != 16'd0) ?
                                      SCAN_FOUND : SCAN_FAIL;
                        end else begin
                            scan_phase = PH_SCAN;
                        end
                    end
                end
                default: scan_phase = PH_SCAN;
            endcase
            // buffer ran out before a decision
            if (verdict == SCAN_OPEN && last) verdict = SCAN_FAIL;
            if (verdict != SCAN_OPEN) begin
                size_decided = 1'b1;
                res.found        = (verdict == SCAN_FOUND);
                res.image_width  = res.found ? cap_width : 16'd0;
                res.image_height = res.found ? cap_height : 16'd0;
                frame_size_q.push_back(res);
            end
        end
        if (last) clear_scan_state();
    endtask

    // Move the staged buffer into the pending queue, flagging its final byte
    task automatic flush_buffer();
        t_stream_byte item;
        foreach (buf_q[i]) begin
            item.data = buf_q[i];
            item.last = (i == buf_q.size() - 1);
            byte_q.push_back(item);
        end
        buf_q.delete();
    endtask

    function automatic logic [15:0] pick_dimension();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return 16'd0;
        if (roll == 1) return 16'hffff;
        return 16'($urandom_range(1, 65535));
    endfunction

    // One marker segment, optionally a frame header
    task automatic stage_segment(input bit want_sof);
        logic [7:0]  mk;
        logic [15:0] seg_len;
        logic [15:0] dim_h;
        logic [15:0] dim_w;
        int          body_n;
        // stray bytes between segments, then prefix and fill
        repeat ($urandom_range(0, 2)) buf_q.push_back(8'($urandom_range(0, 254)));
        buf_q.push_back(BYTE_PREFIX);
        repeat ($urandom_range(0, 2)) buf_q.push_back(BYTE_PREFIX);
        if (want_sof) begin
            do mk = 8'(MARK_SOF0 + $urandom_range(0, 15)); while (!is_sof_marker(mk));
        end else begin
            do mk = 8'($urandom_range(0, 255));
            while (mk == BYTE_PREFIX || mk == MARK_EOI || mk == MARK_SOS);
        end
        buf_q.push_back(mk);
        if ($urandom_range(0, 39) == 0) seg_len = 16'($urandom_range(256, 65535));
        else if (want_sof) seg_len = ($urandom_range(0, 3) == 0) ?
                                     16'($urandom_range(0, 8)) : 16'($urandom_range(7, 12));
        else seg_len = ($urandom_range(0, 7) == 0) ?
                       16'($urandom_range(0, 1)) : 16'($urandom_range(2, 8));
        buf_q.push_back(seg_len[15:8]);
        buf_q.push_back(seg_len[7:0]);
        body_n = (seg_len < 16'd2) ? 0 : ((seg_len > 16'd14) ? 12 : int'(seg_len) - 2);
        dim_h = pick_dimension();
        dim_w = pick_dimension();
        for (int k = 0; k < body_n; k++) begin
            if (want_sof && k == 1) buf_q.push_back(dim_h[15:8]);
            else if (want_sof && k == 2) buf_q.push_back(dim_h[7:0]);
            else if (want_sof && k == 3) buf_q.push_back(dim_w[15:8]);
            else if (want_sof && k == 4) buf_q.push_back(dim_w[7:0]);
            else buf_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed buffers with random content, some noise and damage
    task automatic stage_random_buffer();
        int shape;
        int keep;
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            buf_q.push_back((shape < 11) ? 8'($urandom_range(0, 255)) : BYTE_PREFIX);
            buf_q.push_back((shape < 14) ? 8'($urandom_range(0, 255)) : MARK_SOI);
            repeat ($urandom_range(0, 3)) stage_segment(1'b0);
            if ($urandom_range(0, 9) == 0) begin
                buf_q.push_back(BYTE_PREFIX);
                buf_q.push_back($urandom_range(0, 1) ? MARK_EOI : MARK_SOS);
            end else begin
                stage_segment(1'b1);
            end
            repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) == 0) begin
                keep = $urandom_range(1, buf_q.size());
                while (buf_q.size() > keep) void'(buf_q.pop_back());
            end
        end
        flush_buffer();
    endtask

    // Sender: offers queued bytes, random gap drawn per request
    always @(posedge i_clk) begin : tx_side
        int  tx_gap;
        bit  tx_busy;
        bit  take;
        t_stream_byte item;
        if (i_rst_n) begin
            take = i_s_axis_tvalid && o_s_axis_tready;
            if (take) begin
                scan_jpeg_byte(i_s_axis_tdata, i_s_axis_tlast);
                n_accepted++;
            end
            if (take || !i_s_axis_tvalid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    item = byte_q.pop_front();
                    i_s_axis_tdata  <= item.data;
                    i_s_axis_tlast  <= item.last;
                    i_s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) tx_busy = !tx_busy;
                    tx_gap = tx_busy ? 0 : $urandom_range(0, 17);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once traffic is under way
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (!rx_hold_done && n_accepted >= HOLD_AFTER) begin
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
        end
    end

    // Receiver: checks each result request against the oldest expectation
    always @(posedge i_clk) begin : rx_side
        int      rx_gap;
        bit      rx_busy;
        bit      got;
        t_result want;
        if (i_rst_n) begin
            got = o_m_axis_tvalid && i_m_axis_tready;
            if (got) begin
                if (frame_size_q.size() == 0) begin
                    flag_mismatch("result with nothing expected");
                end else begin
                    want = frame_size_q.pop_front();
                    if (o_m_axis_tuser !== want.found)
                        flag_mismatch($sformatf("found %b, want %b",
                                                o_m_axis_tuser, want.found));
                    if (o_m_axis_tdata[15:0] !== want.image_width)
                        flag_mismatch($sformatf("width %0d, want %0d",
                                                o_m_axis_tdata[15:0], want.image_width));
                    if (o_m_axis_tdata[31:16] !== want.image_height)
                        flag_mismatch($sformatf("height %0d, want %0d",
                                                o_m_axis_tdata[31:16], want.image_height));
                end
            end
            if (rx_hold_left != 0) begin
                i_m_axis_tready <= 1'b0;
            end else if (got || !i_m_axis_tready) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) rx_busy = !rx_busy;
                    rx_gap = rx_busy ? 0 : $urandom_range(0, 17);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        clear_scan_state();
        // single non-prefix byte
        buf_q = '{8'h00};
        flush_buffer();
        // fill byte, then start of scan decides early; tail swallowed
        buf_q = '{BYTE_PREFIX, MARK_SOI, BYTE_PREFIX, BYTE_PREFIX, MARK_SOS, 8'h12};
        flush_buffer();
        // restart marker read as having a length, which is below the minimum
        buf_q = '{BYTE_PREFIX, MARK_SOI, BYTE_PREFIX, MARK_RST0, 8'h00, 8'h01};
        flush_buffer();
        // shortest frame header with largest sizes, ends on the final byte
        buf_q = '{BYTE_PREFIX, MARK_SOI, BYTE_PREFIX, MARK_SOF0, 8'h00, 8'h07,
                  8'h08, 8'hff, 8'hff, 8'hff, 8'hff};
        flush_buffer();
        while (byte_q.size() < TOTAL_BYTES) stage_random_buffer();
        n_total = byte_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (frame_size_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/jfss_pkg.sv
rtl/core/jfss_parser.sv
rtl/core/jpeg_frame_size_scanner_unit.sv
sim/tb_jpeg_frame_size_scanner_unit.sv
